### rtl/rdpd_pkg.sv
`timescale 1ns / 1ps

package rdpd_pkg;

	localparam int unsigned TICK_W  = 16;
	localparam int unsigned PULSE_W = 4;
	localparam int unsigned DIGIT_W = 4;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [TICK_W-1:0]  TICK_MAX        = '1;
	localparam logic [PULSE_W-1:0] PULSE_MAX       = '1;
	localparam logic [PULSE_W-1:0] PULSES_FOR_ZERO = PULSE_W'(10);

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_BREAK_MIN = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_BREAK_MAX = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_PAUSE     = CFG_IDX_W'(2);

	localparam logic [TICK_W-1:0] BREAK_MIN_RST = TICK_W'(45);
	localparam logic [TICK_W-1:0] BREAK_MAX_RST = TICK_W'(75);
	localparam logic [TICK_W-1:0] PAUSE_RST     = TICK_W'(700);

	typedef struct packed {
		logic [TICK_W-1:0] break_min_ticks;
		logic [TICK_W-1:0] break_max_ticks;
		logic [TICK_W-1:0] pause_ticks;
	} cfg_t;

	typedef struct packed {
		logic               digit_done;
		logic               digit_valid;
		logic [DIGIT_W-1:0] digit_value;
	} result_t;

endpackage

### rtl/rdpd_if.sv
`timescale 1ns / 1ps

interface rdpd_line_if;
	logic valid;
	logic ready;
	logic line_made;

	modport source (output valid, output line_made, input ready);
	modport sink   (input valid, input line_made, output ready);
endinterface

interface rdpd_digit_if
	import rdpd_pkg::*;
;
	logic               valid;
	logic               ready;
	logic               digit_done;
	logic               digit_valid;
	logic [DIGIT_W-1:0] digit_value;

	modport source (output valid, output digit_done, output digit_valid,
		output digit_value, input ready);
	modport sink   (input valid, input digit_done, input digit_valid,
		input digit_value, output ready);
endinterface

### rtl/rotary_dial_pulse_decoder.sv
`timescale 1ns / 1ps

// Rotary dial pulse decoder. Feed one loop sample per tick on the line channel
// (line_made high means the loop is made). Each open interval is timed; when
// the loop closes, a break whose length lies within break_min_ticks to
// break_max_ticks counts as one dial pulse. Once the loop has stayed closed for
// pause_ticks with at least one pulse counted, the word on the digit channel
// carries digit_done high: ten pulses give 0, one to nine give that digit, and
// more than ten give digit_valid low with value 0. Every sample yields exactly
// one word, with digit_done low on ticks that end no digit. Break and make
// timers saturate at 65535; the pulse count saturates at 15. A single
// counter-and-compare pass updates the timers and feeds a one-word output
// register, so a new sample is taken every cycle as long as the output side
// keeps taking words. Write the three registers through the
// cfg port (index 0 break min, 1 break max, 2 pause) only while idle; other
// indexes are ignored.
module rotary_dial_pulse_decoder
	import rdpd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]    cfg_wdata,
	rdpd_line_if.sink            line,
	rdpd_digit_if.source         digit
);

	cfg_t    cfg;
	result_t step_result;
	result_t out_word;
	logic    can_load;
	logic    accept;
	logic    out_valid;

	// Hold the register file
	rdpd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Take a sample whenever the output register can accept its word
	assign line.ready = can_load;
	assign accept     = line.valid && can_load;

	// Advance timers and pulse count, decode the digit
	rdpd_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.accept    (accept),
		.line_made (line.line_made),
		.result    (step_result)
	);

	// Hold the result word until the sink takes it
	rdpd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.result    (step_result),
		.take      (digit.ready),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_word  (out_word)
	);

	assign digit.valid       = out_valid;
	assign digit.digit_done  = out_word.digit_done;
	assign digit.digit_valid = out_word.digit_valid;
	assign digit.digit_value = out_word.digit_value;

endmodule

### rtl/rdpd_cfg_regs.sv
`timescale 1ns / 1ps

module rdpd_cfg_regs
	import rdpd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]    cfg_wdata,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	// Unknown indexes drop the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.break_min_ticks <= BREAK_MIN_RST;
			cfg_q.break_max_ticks <= BREAK_MAX_RST;
			cfg_q.pause_ticks     <= PAUSE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BREAK_MIN: cfg_q.break_min_ticks <= cfg_wdata;
				REG_BREAK_MAX: cfg_q.break_max_ticks <= cfg_wdata;
				REG_PAUSE:     cfg_q.pause_ticks     <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/rdpd_step.sv
`timescale 1ns / 1ps

module rdpd_step
	import rdpd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    accept,
	input  logic    line_made,
	output result_t result
);

	logic [TICK_W-1:0]  break_count_q;
	logic [TICK_W-1:0]  make_count_q;
	logic [PULSE_W-1:0] pulse_count_q;
	logic               prev_closed_q;

	logic [TICK_W-1:0]  break_next;
	logic [TICK_W-1:0]  make_next;
	logic [PULSE_W-1:0] pulse_mid;
	logic [PULSE_W-1:0] pulse_next;
	logic               in_window;
	logic               pulse_inc;
	logic               fire;

	always_comb begin
		in_window = (break_count_q >= cfg.break_min_ticks) &&
			(break_count_q <= cfg.break_max_ticks);
		pulse_inc = line_made && !prev_closed_q && in_window &&
			(pulse_count_q != PULSE_MAX);
		pulse_mid = pulse_count_q + PULSE_W'(pulse_inc);

		if (!line_made) begin
			break_next = (break_count_q == TICK_MAX) ? break_count_q
				: break_count_q + TICK_W'(1);
			make_next  = '0;
		end else begin
			break_next = prev_closed_q ? break_count_q : '0;
			make_next  = (make_count_q == TICK_MAX) ? make_count_q
				: make_count_q + TICK_W'(1);
		end

		fire = line_made && (pulse_mid != '0) && (make_next >= cfg.pause_ticks);

		result.digit_done  = fire;
		result.digit_valid = fire && (pulse_mid <= PULSES_FOR_ZERO);
		result.digit_value = (fire && (pulse_mid < PULSES_FOR_ZERO))
			? DIGIT_W'(pulse_mid) : '0;

		if (fire) begin
			pulse_next = '0;
		end else begin
			pulse_next = pulse_mid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			break_count_q <= '0;
			make_count_q  <= '0;
			pulse_count_q <= '0;
			prev_closed_q <= 1'b1;
		end else if (accept) begin
			break_count_q <= break_next;
			make_count_q  <= make_next;
			pulse_count_q <= pulse_next;
			prev_closed_q <= line_made;
		end
	end

endmodule

### rtl/rdpd_out_reg.sv
`timescale 1ns / 1ps

module rdpd_out_reg
	import rdpd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t result,
	input  logic    take,
	output logic    can_load,
	output logic    out_valid,
	output result_t out_word
);

	logic    valid_q;
	result_t word_q;

	// Free when empty or when the held word leaves this cycle
	assign can_load  = !valid_q || take;
	assign out_valid = valid_q;
	assign out_word  = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= result;
		end
	end

endmodule
